/* sv/sia_pkg.sv */
// ----------------------------------------------------------------------------
// sia_pkg
// Types, constants and helper functions shared by the interval ALU.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int BW         = 32;
    localparam int DIV_STAGES = BW;

    typedef logic signed [BW-1:0]   bound_t;
    typedef logic        [BW-1:0]   umag_t;
    typedef logic signed [BW:0]     wide_t;
    typedef logic signed [2*BW-1:0] prod_t;

    localparam bound_t INT_MIN = {1'b1, {(BW-1){1'b0}}};
    localparam bound_t INT_MAX = {1'b0, {(BW-1){1'b1}}};
    localparam bound_t ONE     = bound_t'(1);
    localparam bound_t NEG_ONE = '1;
    localparam bound_t ZERO    = '0;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MOD = 3'd4
    } cmd_t;

    // Stage-two result of the operand prep logic
    typedef struct packed {
        logic [2:0] cmd;
        bound_t     as_lo;
        bound_t     as_hi;
        prod_t      prod0;
        prod_t      prod1;
        prod_t      prod2;
        prod_t      prod3;
        bound_t     mod_lo;
        bound_t     mod_hi;
        bound_t     a_lo;
        bound_t     a_hi;
        logic       split;
        logic       div_full;
        logic [3:0] qneg;
        umag_t      dvd_lo;
        umag_t      dvd_hi;
        umag_t      dsr_x;
        umag_t      dsr_y;
    } prep_t;

    // Data riding alongside the divider lanes
    typedef struct packed {
        logic       is_div;
        logic       div_full;
        logic       split;
        logic [3:0] qneg;
        bound_t     a_lo;
        bound_t     a_hi;
        bound_t     res_lo;
        bound_t     res_hi;
    } side_t;

    function automatic wide_t ext(bound_t v);
        wide_t w;
        w = {v[BW-1], v};
        return w;
    endfunction

    function automatic bound_t sat_wide(wide_t v);
        bound_t r;
        if (v[BW] != v[BW-1])
        begin
            r = v[BW] ? INT_MIN : INT_MAX;
        end
        else
        begin
            r = v[BW-1:0];
        end
        return r;
    endfunction

    function automatic umag_t mag(bound_t v);
        wide_t w;
        wide_t n;
        w = ext(v);
        n = -w;
        return v[BW-1] ? n[BW-1:0] : w[BW-1:0];
    endfunction

endpackage

/* sv/sia_if.sv */
// ----------------------------------------------------------------------------
// sia_req_if / sia_rsp_if
// Valid/ready channels carrying operand and result intervals.
// ----------------------------------------------------------------------------
interface sia_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] a_lo;
    logic signed [31:0] a_hi;
    logic signed [31:0] b_lo;
    logic signed [31:0] b_hi;

    modport source (output valid, command, a_lo, a_hi, b_lo, b_hi, input ready);
    modport sink   (input valid, command, a_lo, a_hi, b_lo, b_hi, output ready);
endinterface

interface sia_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_lo;
    logic signed [31:0] result_hi;

    modport source (output valid, result_lo, result_hi, input ready);
    modport sink   (input valid, result_lo, result_hi, output ready);
endinterface

/* sv/sia_prep.sv */
// ----------------------------------------------------------------------------
// sia_prep
// Operand prep: saturating add/sub, corner products, modulo bound and
// divisor repair / magnitude split for the divider lanes.
// ----------------------------------------------------------------------------
module sia_prep (
    input  logic [2:0]      cmd,
    input  sia_pkg::bound_t a_lo,
    input  sia_pkg::bound_t a_hi,
    input  sia_pkg::bound_t b_lo,
    input  sia_pkg::bound_t b_hi,
    output sia_pkg::prep_t  prep
);
    import sia_pkg::*;

    logic   sub_op;
    wide_t  lo_sum;
    wide_t  hi_sum;
    prod_t  p0, p1, p2, p3;
    logic   both_zero;
    umag_t  ml, mr, mmax, ub;
    bound_t ub_s;
    bound_t x, y;
    logic   split;

    always_comb
    begin
        sub_op = (cmd == CMD_SUB);
        lo_sum = sub_op ? ext(a_lo) - ext(b_hi) : ext(a_lo) + ext(b_lo);
        hi_sum = sub_op ? ext(a_hi) - ext(b_lo) : ext(a_hi) + ext(b_hi);

        p0 = prod_t'(a_lo) * prod_t'(b_lo);
        p1 = prod_t'(a_lo) * prod_t'(b_hi);
        p2 = prod_t'(a_hi) * prod_t'(b_lo);
        p3 = prod_t'(a_hi) * prod_t'(b_hi);

        both_zero = (b_lo == ZERO) && (b_hi == ZERO);
        ml   = mag(b_lo);
        mr   = mag(b_hi);
        mmax = (ml > mr) ? ml : mr;
        ub   = mmax - umag_t'(1);
        ub_s = ub;

        split = b_lo[BW-1] && !b_hi[BW-1] && (b_hi != ZERO);
        x = b_lo;
        y = b_hi;
        if (!split)
        begin
            if (b_lo == ZERO)
            begin
                x = b_hi[BW-1] ? NEG_ONE : ONE;
            end
            if (b_hi == ZERO)
            begin
                y = x[BW-1] ? NEG_ONE : ONE;
            end
        end

        prep.cmd   = cmd;
        prep.as_lo = (lo_sum[BW] != lo_sum[BW-1]) ? INT_MIN : lo_sum[BW-1:0];
        prep.as_hi = (hi_sum[BW] != hi_sum[BW-1]) ? INT_MAX : hi_sum[BW-1:0];
        prep.prod0 = p0;
        prep.prod1 = p1;
        prep.prod2 = p2;
        prep.prod3 = p3;

        if (both_zero)
        begin
            prep.mod_lo = INT_MIN;
            prep.mod_hi = INT_MAX;
        end
        else if ((mag(a_hi) < ub) && (mag(a_lo) < ub))
        begin
            prep.mod_lo = a_lo;
            prep.mod_hi = a_hi;
        end
        else if (!a_lo[BW-1])
        begin
            prep.mod_lo = ZERO;
            prep.mod_hi = ub_s;
        end
        else if (a_hi[BW-1] || (a_hi == ZERO))
        begin
            prep.mod_lo = -ub_s;
            prep.mod_hi = ZERO;
        end
        else
        begin
            prep.mod_lo = -ub_s;
            prep.mod_hi = ub_s;
        end

        prep.a_lo     = a_lo;
        prep.a_hi     = a_hi;
        prep.split    = split;
        prep.div_full = both_zero;
        prep.qneg     = {a_hi[BW-1] ^ y[BW-1], a_lo[BW-1] ^ y[BW-1],
                         a_hi[BW-1] ^ x[BW-1], a_lo[BW-1] ^ x[BW-1]};
        prep.dvd_lo   = mag(a_lo);
        prep.dvd_hi   = mag(a_hi);
        prep.dsr_x    = mag(x);
        prep.dsr_y    = mag(y);
    end

endmodule

/* sv/sia_udiv.sv */
// ----------------------------------------------------------------------------
// sia_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sia_udiv (
    input  logic           clk,
    input  logic           en,
    input  sia_pkg::umag_t dividend,
    input  sia_pkg::umag_t divisor,
    output sia_pkg::umag_t quotient
);
    import sia_pkg::*;

    umag_t rem_reg [0:DIV_STAGES-2];
    umag_t dvd_reg [0:DIV_STAGES-2];
    umag_t dsr_reg [0:DIV_STAGES-2];
    umag_t q_reg   [0:DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        umag_t           src_rem, src_dvd, src_dsr, src_q;
        logic [BW+1:0]   trial;
        logic [BW+1:0]   diff;
        logic            take;
        umag_t           rem_next;
        umag_t           q_next;

        if (k == 0)
        begin : g_first
            assign src_rem = '0;
            assign src_dvd = dividend;
            assign src_dsr = divisor;
            assign src_q   = '0;
        end
        else
        begin : g_next
            assign src_rem = rem_reg[k-1];
            assign src_dvd = dvd_reg[k-1];
            assign src_dsr = dsr_reg[k-1];
            assign src_q   = q_reg[k-1];
        end

        always_comb
        begin
            trial    = {1'b0, src_rem, src_dvd[BW-1]};
            diff     = trial - {2'b00, src_dsr};
            take     = !diff[BW+1];
            rem_next = take ? diff[BW-1:0] : trial[BW-1:0];
            q_next   = {src_q[BW-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= q_next;
            end
        end

        if (k < DIV_STAGES-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    dvd_reg[k] <= {src_dvd[BW-2:0], 1'b0};
                    dsr_reg[k] <= src_dsr;
                end
            end
        end
    end

    assign quotient = q_reg[DIV_STAGES-1];

endmodule

/* sv/sia_finish.sv */
// ----------------------------------------------------------------------------
// sia_finish
// Signs and clamps the corner quotients, takes their hull and picks the
// final result interval. Two register stages; the second is the output.
// ----------------------------------------------------------------------------
module sia_finish (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld,
    input  sia_pkg::side_t  side,
    input  sia_pkg::umag_t  q0,
    input  sia_pkg::umag_t  q1,
    input  sia_pkg::umag_t  q2,
    input  sia_pkg::umag_t  q3,
    output logic            out_vld,
    output sia_pkg::bound_t out_lo,
    output sia_pkg::bound_t out_hi
);
    import sia_pkg::*;

    logic   f1_vld_reg;
    logic   f2_vld_reg;
    bound_t cand_reg  [0:7];
    bound_t cand_next [0:7];
    logic   is_div_reg, full_reg;
    bound_t res_lo_reg, res_hi_reg;
    bound_t lo_reg, hi_reg;
    bound_t lo_next, hi_next;
    umag_t  qm [0:3];
    wide_t  qw;
    bound_t mn1 [0:3], mx1 [0:3], mn2 [0:1], mx2 [0:1];

    always_comb
    begin
        qm[0] = q0;
        qm[1] = q1;
        qm[2] = q2;
        qm[3] = q3;
        qw    = '0;
        for (int i = 0; i < 4; i++)
        begin
            qw = {1'b0, qm[i]};
            if (side.qneg[i])
            begin
                qw = -qw;
            end
            cand_next[i] = sat_wide(qw);
        end
        // split divisor: -1 and +1 corners
        if (side.split)
        begin
            cand_next[4] = side.a_lo;
            cand_next[5] = side.a_hi;
            cand_next[6] = sat_wide(-ext(side.a_lo));
            cand_next[7] = sat_wide(-ext(side.a_hi));
        end
        else
        begin
            cand_next[4] = cand_next[0];
            cand_next[5] = cand_next[0];
            cand_next[6] = cand_next[0];
            cand_next[7] = cand_next[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 8; i++)
            begin
                cand_reg[i] <= cand_next[i];
            end
            is_div_reg <= side.is_div;
            full_reg   <= side.div_full;
            res_lo_reg <= side.res_lo;
            res_hi_reg <= side.res_hi;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mn1[i] = (cand_reg[2*i] < cand_reg[2*i+1]) ? cand_reg[2*i] : cand_reg[2*i+1];
            mx1[i] = (cand_reg[2*i] > cand_reg[2*i+1]) ? cand_reg[2*i] : cand_reg[2*i+1];
        end
        for (int i = 0; i < 2; i++)
        begin
            mn2[i] = (mn1[2*i] < mn1[2*i+1]) ? mn1[2*i] : mn1[2*i+1];
            mx2[i] = (mx1[2*i] > mx1[2*i+1]) ? mx1[2*i] : mx1[2*i+1];
        end
        if (!is_div_reg)
        begin
            lo_next = res_lo_reg;
            hi_next = res_hi_reg;
        end
        else if (full_reg)
        begin
            lo_next = INT_MIN;
            hi_next = INT_MAX;
        end
        else
        begin
            lo_next = (mn2[0] < mn2[1]) ? mn2[0] : mn2[1];
            hi_next = (mx2[0] > mx2[1]) ? mx2[0] : mx2[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg <= vld;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    assign out_vld = f2_vld_reg;
    assign out_lo  = lo_reg;
    assign out_hi  = hi_reg;

endmodule

/* sv/saturating_interval_alu.sv */
// ----------------------------------------------------------------------------
// saturating_interval_alu
// Saturating interval arithmetic on signed 32-bit bounds: add, subtract,
// multiply, divide and modulo.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer per cycle in, one per cycle out, through 36
// register stages (input register, operand prep with the corner multipliers,
// 32 divider stages producing one quotient bit each, quotient sign/clamp,
// hull and output register). All commands take the same path so results
// leave in issue order. The pipeline stalls as a whole while a result waits
// on rsp.ready.
module saturating_interval_alu (
    input logic      clk,
    input logic      rst_n,
    sia_req_if.sink  req,
    sia_rsp_if.source rsp
);
    import sia_pkg::*;

    logic       en;
    logic       fin_vld;
    bound_t     fin_lo, fin_hi;

    logic       s1_vld_reg;
    logic [2:0] cmd_reg;
    bound_t     a_lo_reg, a_hi_reg, b_lo_reg, b_hi_reg;

    prep_t      prep_next, prep_reg;
    logic       s2_vld_reg;

    side_t      side_next;
    side_t      side_reg [0:DIV_STAGES-1];
    logic [DIV_STAGES-1:0] dv_vld_reg;

    umag_t      q0, q1, q2, q3;

    logic       mul_ovf;
    bound_t     pl [0:3];
    bound_t     mlo_a, mlo_b, mhi_a, mhi_b;

    assign en        = !fin_vld || rsp.ready;
    assign req.ready = en;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg  <= req.command;
            a_lo_reg <= req.a_lo;
            a_hi_reg <= req.a_hi;
            b_lo_reg <= req.b_lo;
            b_hi_reg <= req.b_hi;
            prep_reg <= prep_next;
        end
    end

    sia_prep u_prep (
        .cmd  (cmd_reg),
        .a_lo (a_lo_reg),
        .a_hi (a_hi_reg),
        .b_lo (b_lo_reg),
        .b_hi (b_hi_reg),
        .prep (prep_next)
    );

    // Multiply hull and result pick for everything but divide
    always_comb
    begin
        mul_ovf = (prep_reg.prod0[2*BW-1:BW-1] != '0 && prep_reg.prod0[2*BW-1:BW-1] != '1)
               || (prep_reg.prod1[2*BW-1:BW-1] != '0 && prep_reg.prod1[2*BW-1:BW-1] != '1)
               || (prep_reg.prod2[2*BW-1:BW-1] != '0 && prep_reg.prod2[2*BW-1:BW-1] != '1)
               || (prep_reg.prod3[2*BW-1:BW-1] != '0 && prep_reg.prod3[2*BW-1:BW-1] != '1);
        pl[0] = prep_reg.prod0[BW-1:0];
        pl[1] = prep_reg.prod1[BW-1:0];
        pl[2] = prep_reg.prod2[BW-1:0];
        pl[3] = prep_reg.prod3[BW-1:0];
        mlo_a = (pl[0] < pl[1]) ? pl[0] : pl[1];
        mlo_b = (pl[2] < pl[3]) ? pl[2] : pl[3];
        mhi_a = (pl[0] > pl[1]) ? pl[0] : pl[1];
        mhi_b = (pl[2] > pl[3]) ? pl[2] : pl[3];

        side_next.is_div   = (prep_reg.cmd == CMD_DIV);
        side_next.div_full = prep_reg.div_full;
        side_next.split    = prep_reg.split;
        side_next.qneg     = prep_reg.qneg;
        side_next.a_lo     = prep_reg.a_lo;
        side_next.a_hi     = prep_reg.a_hi;
        unique case (prep_reg.cmd)
            CMD_ADD, CMD_SUB:
            begin
                side_next.res_lo = prep_reg.as_lo;
                side_next.res_hi = prep_reg.as_hi;
            end
            CMD_MUL:
            begin
                side_next.res_lo = mul_ovf ? INT_MIN : ((mlo_a < mlo_b) ? mlo_a : mlo_b);
                side_next.res_hi = mul_ovf ? INT_MAX : ((mhi_a > mhi_b) ? mhi_a : mhi_b);
            end
            CMD_MOD:
            begin
                side_next.res_lo = prep_reg.mod_lo;
                side_next.res_hi = prep_reg.mod_hi;
            end
            default:
            begin
                side_next.res_lo = INT_MIN;
                side_next.res_hi = INT_MAX;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
        end
        else if (en)
        begin
            s1_vld_reg <= req.valid;
            s2_vld_reg <= s1_vld_reg;
            dv_vld_reg <= {dv_vld_reg[DIV_STAGES-2:0], s2_vld_reg};
        end
    end

    sia_udiv u_div0 (.clk(clk), .en(en), .dividend(prep_reg.dvd_lo),
                     .divisor(prep_reg.dsr_x), .quotient(q0));
    sia_udiv u_div1 (.clk(clk), .en(en), .dividend(prep_reg.dvd_hi),
                     .divisor(prep_reg.dsr_x), .quotient(q1));
    sia_udiv u_div2 (.clk(clk), .en(en), .dividend(prep_reg.dvd_lo),
                     .divisor(prep_reg.dsr_y), .quotient(q2));
    sia_udiv u_div3 (.clk(clk), .en(en), .dividend(prep_reg.dvd_hi),
                     .divisor(prep_reg.dsr_y), .quotient(q3));

    sia_finish u_finish (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (dv_vld_reg[DIV_STAGES-1]),
        .side    (side_reg[DIV_STAGES-1]),
        .q0      (q0),
        .q1      (q1),
        .q2      (q2),
        .q3      (q3),
        .out_vld (fin_vld),
        .out_lo  (fin_lo),
        .out_hi  (fin_hi)
    );

    assign rsp.valid     = fin_vld;
    assign rsp.result_lo = fin_lo;
    assign rsp.result_hi = fin_hi;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp.valid |-> req.ready)
        else $error("input stalled with no pending result");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> s1_vld_reg)
        else $error("accepted transfer did not enter pipeline");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> ($stable(dv_vld_reg) && $stable(s2_vld_reg)))
        else $error("pipeline moved during output stall");

    a_prep_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && req.ready) |=> dv_vld_reg[0])
        else $error("prep stage item lost");

endmodule

/* sim/saturating_interval_alu_tb.sv */
// ----------------------------------------------------------------------------
// saturating_interval_alu_tb
// Checks each result interval of the ALU against a predictor that works on
// 64-bit integers. Stimulus is a directed set of corner cases followed by
// random operand intervals, sent in bursts while the result side stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module saturating_interval_alu_tb;
    import sia_pkg::*;

    localparam longint LMIN = -(64'sd1 <<< 31);
    localparam longint LMAX = (64'sd1 <<< 31) - 1;

    typedef struct {
        logic [2:0] command;
        bound_t     a_lo;
        bound_t     a_hi;
        bound_t     b_lo;
        bound_t     b_hi;
    } op_item_t;

    typedef struct {
        bound_t lo;
        bound_t hi;
    } span_t;

    logic clk;
    logic rst_n;

    sia_req_if req ();
    sia_rsp_if rsp ();

    saturating_interval_alu u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    op_item_t pending_ops[$];
    span_t    expected_spans[$];
    int       errors;
    bit       hold_send;
    bit       req_taken = 1'b0;
    int       burst_left;
    int       gap_left;
    int       stall_phase;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint lclamp(longint v);
        if (v < LMIN)
        begin
            return LMIN;
        end
        if (v > LMAX)
        begin
            return LMAX;
        end
        return v;
    endfunction

    function automatic bit fits(longint v);
        return v >= LMIN && v <= LMAX;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void quot_hull(longint xl, longint xh, longint d0, longint d1,
                                      output longint mn, output longint mx);
        longint xs[2];
        longint ds[2];
        longint q;
        xs[0] = xl;
        xs[1] = xh;
        ds[0] = d0;
        ds[1] = d1;
        mn = LMAX;
        mx = LMIN;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                q = xs[i] / ds[j];
                if (q < mn)
                begin
                    mn = q;
                end
                if (q > mx)
                begin
                    mx = q;
                end
            end
        end
        mn = lclamp(mn);
        mx = lclamp(mx);
    endfunction

    function automatic span_t interval_result(op_item_t it);
        longint al;
        longint ah;
        longint bl;
        longint bh;
        longint t;
        longint lo;
        longint hi;
        longint p;
        longint n0;
        longint n1;
        longint ub;
        span_t  r;
        al = it.a_lo;
        ah = it.a_hi;
        bl = it.b_lo;
        bh = it.b_hi;
        lo = LMIN;
        hi = LMAX;
        case (it.command)
            CMD_ADD:
            begin
                t = al + bl;
                lo = fits(t) ? t : LMIN;
                t = ah + bh;
                hi = fits(t) ? t : LMAX;
            end
            CMD_SUB:
            begin
                t = al - bh;
                lo = fits(t) ? t : LMIN;
                t = ah - bl;
                hi = fits(t) ? t : LMAX;
            end
            CMD_MUL:
            begin
                longint xs[2];
                longint ys[2];
                bit     ovf;
                xs[0] = al;
                xs[1] = ah;
                ys[0] = bl;
                ys[1] = bh;
                ovf = 1'b0;
                lo = LMAX;
                hi = LMIN;
                for (int i = 0; i < 2; i++)
                begin
                    for (int j = 0; j < 2; j++)
                    begin
                        p = xs[i] * ys[j];
                        if (!fits(p))
                        begin
                            ovf = 1'b1;
                        end
                        if (p < lo)
                        begin
                            lo = p;
                        end
                        if (p > hi)
                        begin
                            hi = p;
                        end
                    end
                end
                if (ovf)
                begin
                    lo = LMIN;
                    hi = LMAX;
                end
            end
            CMD_DIV:
            begin
                if (!(bl == 0 && bh == 0))
                begin
                    if (bl < 0 && bh > 0)
                    begin
                        quot_hull(al, ah, bl, -1, lo, hi);
                        quot_hull(al, ah, 1, bh, n0, n1);
                        lo = n0 < lo ? n0 : lo;
                        hi = n1 > hi ? n1 : hi;
                    end
                    else
                    begin
                        if (bl == 0)
                        begin
                            bl = bh < 0 ? -1 : 1;
                        end
                        if (bh == 0)
                        begin
                            bh = bl < 0 ? -1 : 1;
                        end
                        quot_hull(al, ah, bl, bh, lo, hi);
                    end
                end
            end
            CMD_MOD:
            begin
                ub = (absl(bl) > absl(bh) ? absl(bl) : absl(bh)) - 1;
                if (!(bl == 0 && bh == 0))
                begin
                    if (absl(ah) < ub && absl(al) < ub)
                    begin
                        lo = al;
                        hi = ah;
                    end
                    else if (al >= 0)
                    begin
                        lo = 0;
                        hi = ub;
                    end
                    else if (ah <= 0)
                    begin
                        lo = -ub;
                        hi = 0;
                    end
                    else
                    begin
                        lo = -ub;
                        hi = ub;
                    end
                end
            end
            default:
            begin
                lo = LMIN;
                hi = LMAX;
            end
        endcase
        r.lo = bound_t'(lo);
        r.hi = bound_t'(hi);
        return r;
    endfunction

    function automatic bound_t pick_bound();
        case ($urandom_range(0, 9))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return ZERO;
            3: return bound_t'($urandom_range(0, 4)) - 2;
            4: return bound_t'($urandom_range(0, 200)) - 100;
            5: return bound_t'($urandom_range(0, 131070)) - 65535;
            6: return INT_MIN + bound_t'($urandom_range(0, 3));
            7: return INT_MAX - bound_t'($urandom_range(0, 3));
            default: return bound_t'($urandom());
        endcase
    endfunction

    task automatic add_op(logic [2:0] c, bound_t al, bound_t ah, bound_t bl, bound_t bh);
        op_item_t it;
        it.command = c;
        it.a_lo = al;
        it.a_hi = ah;
        it.b_lo = bl;
        it.b_hi = bh;
        pending_ops.push_back(it);
    endtask

    // request transfer seen at the last rising edge
    always @(posedge clk)
    begin
        req_taken <= rst_n && req.valid && req.ready;
    end

    // sender: bursts and gaps, changes on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else if (!req.valid || req_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (pending_ops.size() > 0 && !hold_send)
            begin
                op_item_t it;
                it = pending_ops.pop_front();
                req.valid   <= 1'b1;
                req.command <= it.command;
                req.a_lo    <= it.a_lo;
                req.a_hi    <= it.a_hi;
                req.b_lo    <= it.b_lo;
                req.b_hi    <= it.b_hi;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[9])
        begin
            rsp.ready <= 1'b1;
        end
        else if (stall_phase[8])
        begin
            rsp.ready <= (stall_phase[2:0] != 3'd5);
        end
        else
        begin
            rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // request transfers feed the predictor; result transfers are checked
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
        begin
            op_item_t it;
            it.command = req.command;
            it.a_lo = req.a_lo;
            it.a_hi = req.a_hi;
            it.b_lo = req.b_lo;
            it.b_hi = req.b_hi;
            expected_spans.push_back(interval_result(it));
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_spans.size() == 0)
            begin
                $display("%0t: unexpected result transfer lo=%0d hi=%0d",
                         $time, rsp.result_lo, rsp.result_hi);
                errors++;
            end
            else
            begin
                span_t e;
                e = expected_spans.pop_front();
                if (rsp.result_lo !== e.lo)
                begin
                    $display("%0t: result_lo expected %0d actual %0d",
                             $time, e.lo, rsp.result_lo);
                    errors++;
                end
                if (rsp.result_hi !== e.hi)
                begin
                    $display("%0t: result_hi expected %0d actual %0d",
                             $time, e.hi, rsp.result_hi);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        bound_t edges[6];
        errors      = 0;
        hold_send   = 1'b0;
        burst_left  = 0;
        gap_left    = 0;
        stall_phase = 0;
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.command = CMD_ADD;
        req.a_lo    = '0;
        req.a_hi    = '0;
        req.b_lo    = '0;
        req.b_hi    = '0;
        rsp.ready   = 1'b0;

        edges[0] = INT_MIN;
        edges[1] = INT_MAX;
        edges[2] = ZERO;
        edges[3] = NEG_ONE;
        edges[4] = ONE;
        edges[5] = 32'sd7;

        add_op(CMD_ADD, INT_MIN, INT_MAX, NEG_ONE, ONE);
        add_op(CMD_ADD, 32'sd5, 32'sd10, 32'sd3, 32'sd4);
        add_op(CMD_SUB, INT_MIN, INT_MAX, ONE, NEG_ONE);
        add_op(CMD_SUB, -32'sd5, 32'sd9, -32'sd2, 32'sd3);
        add_op(CMD_MUL, -32'sd3, 32'sd4, -32'sd5, 32'sd6);
        add_op(CMD_MUL, 32'sd65536, 32'sd65536, 32'sd32768, 32'sd32768);
        add_op(CMD_MUL, 32'sd65536, 32'sd65536, -32'sd32768, -32'sd32768);
        add_op(CMD_DIV, -32'sd100, 32'sd50, -32'sd7, 32'sd3);
        add_op(CMD_DIV, 32'sd10, 32'sd20, ZERO, ZERO);
        add_op(CMD_DIV, 32'sd10, 32'sd20, ZERO, 32'sd4);
        add_op(CMD_DIV, 32'sd10, 32'sd20, -32'sd4, ZERO);
        add_op(CMD_DIV, INT_MIN, INT_MIN, NEG_ONE, NEG_ONE);
        add_op(CMD_DIV, INT_MIN, INT_MAX, INT_MIN, INT_MAX);
        add_op(CMD_MOD, -32'sd3, 32'sd3, 32'sd10, 32'sd10);
        add_op(CMD_MOD, 32'sd3, 32'sd30, -32'sd10, 32'sd5);
        add_op(CMD_MOD, -32'sd30, -32'sd3, 32'sd10, 32'sd10);
        add_op(CMD_MOD, -32'sd30, 32'sd30, INT_MIN, INT_MIN);
        add_op(CMD_MOD, 32'sd1, 32'sd2, ZERO, ZERO);
        add_op(CMD_ADD, 32'sd10, -32'sd10, 32'sd3, 32'sd1);
        add_op(3'd5, ONE, ONE, ONE, ONE);
        add_op(3'd7, INT_MIN, INT_MAX, ZERO, ZERO);
        for (int i = 0; i < 6; i++)
        begin
            add_op(CMD_DIV, edges[i], edges[5 - i], edges[(i + 2) % 6], edges[(i + 3) % 6]);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // let the directed set drain completely before random traffic
        wait (pending_ops.size() == 0);
        hold_send = 1'b1;
        wait (expected_spans.size() == 0 && !req.valid);
        hold_send = 1'b0;

        for (int n = 0; n < 1650; n++)
        begin
            logic [2:0] c;
            c = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            add_op(c, pick_bound(), pick_bound(), pick_bound(), pick_bound());
        end
        wait (pending_ops.size() == 0);
        wait (expected_spans.size() == 0 && !req.valid);
        repeat (60) @(posedge clk);
        if (errors == 0)
        begin
            $display("saturating_interval_alu regression: pass");
        end
        else
        begin
            $display("saturating_interval_alu regression: fail");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("saturating_interval_alu regression: fail");
        $finish;
    end

endmodule

/* sim.f */
sv/sia_pkg.sv
sv/sia_if.sv
sv/sia_prep.sv
sv/sia_udiv.sv
sv/sia_finish.sv
sv/saturating_interval_alu.sv
sim/saturating_interval_alu_tb.sv
